/* hdl/lzf_pkg.sv */
`default_nettype none

package lzf_pkg;

    // field widths fixed by the interface
    localparam int CH_W     = 12;
    localparam int ZONE_W   = 4;
    localparam int IDLE_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // one rgb color as held in the stores
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } color_t;

    localparam int COLOR_W = $bits(color_t);

    // request codes
    typedef enum logic [1:0] {
        REQ_HOME = 2'd0,
        REQ_LIVE = 2'd1,
        REQ_TICK = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd1;

    // reset values of the configuration registers
    localparam logic [CH_W-1:0]   FADE_STEP_RST = 12'd82;
    localparam logic [IDLE_W-1:0] TIMEOUT_RST   = 16'd100;
    localparam logic [IDLE_W-1:0] IDLE_MAX      = 16'hFFFF;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT_LIVE,
        ST_COPY,
        ST_FADE,
        ST_EMIT_SHOWN
    } state_t;

endpackage

`default_nettype wire

/* hdl/lzf_ram.sv */
`default_nettype none

module lzf_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 10,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AddrW-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AddrW-1:0] raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/lzf_fade.sv */
`default_nettype none

module lzf_fade (
    input  wire lzf_pkg::color_t           cur,
    input  wire lzf_pkg::color_t           goal,
    input  wire logic [lzf_pkg::CH_W-1:0]  step,
    output lzf_pkg::color_t                nxt,
    output logic                           moved
);

    // move one channel toward its goal by at most step
    function automatic logic [lzf_pkg::CH_W-1:0] approach(
        input logic [lzf_pkg::CH_W-1:0] c,
        input logic [lzf_pkg::CH_W-1:0] g,
        input logic [lzf_pkg::CH_W-1:0] s
    );
        logic [lzf_pkg::CH_W-1:0] gap;
        logic [lzf_pkg::CH_W-1:0] res;
        if (g > c)
        begin
            gap = g - c;
            res = (gap <= s) ? g : c + s;
        end
        else
        begin
            gap = c - g;
            res = (gap <= s) ? g : c - s;
        end
        return res;
    endfunction

    // three channels side by side
    always_comb
    begin
        nxt.red   = approach(cur.red,   goal.red,   step);
        nxt.green = approach(cur.green, goal.green, step);
        nxt.blue  = approach(cur.blue,  goal.blue,  step);
        moved     = (cur != goal);
    end

endmodule

`default_nettype wire

/* hdl/led_zone_fade_and_source_switch_unit.sv */
`default_nettype none

// Multi-zone RGB LED controller: home targets faded by a step per tick, live frames shown at
// once, with a return to home mode after an idle timeout. All three color stores sit in
// single-port-read RAMs of ZONE_COUNT entries (N) and are walked one zone per cycle. A home
// write, a live write without frame end, a tick in live mode that does not expire, and an
// unused request code all finish in the accept cycle and busy stays low. A live write with
// frame end keeps busy high for an emit pass that emits the N zones on consecutive cycles.
// An expiring tick runs a copy pass from the live store to the shown store with no results.
// A home mode tick runs a fade pass (read, step, write back one zone a cycle) and, if any
// channel moved, an emit pass of the shown store. Results come one per cycle marked by
// out_valid and cannot be held off; frame_last marks zone N-1. Reset clears the stores
// through per-zone valid bits, so no clearing pass is needed and the block is ready right
// after reset.
module led_zone_fade_and_source_switch_unit #(
    parameter int ZONE_COUNT = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // command side
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    req_type,
    input  wire logic [lzf_pkg::ZONE_W-1:0]    zone,
    input  wire logic [lzf_pkg::CH_W-1:0]      red,
    input  wire logic [lzf_pkg::CH_W-1:0]      green,
    input  wire logic [lzf_pkg::CH_W-1:0]      blue,
    input  wire logic                          frame_end,
    // configuration port
    input  wire logic                          cfg_we,
    input  wire logic [lzf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lzf_pkg::CFG_W-1:0]     cfg_data,
    // result side
    output logic                               out_valid,
    output logic      [lzf_pkg::ZONE_W-1:0]    out_zone,
    output logic      [lzf_pkg::CH_W-1:0]      out_red,
    output logic      [lzf_pkg::CH_W-1:0]      out_green,
    output logic      [lzf_pkg::CH_W-1:0]      out_blue,
    output logic                               frame_last
);

    localparam int AW    = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
    localparam int CW    = AW + 1;
    localparam int ZoneW = lzf_pkg::ZONE_W;
    localparam int ChW   = lzf_pkg::CH_W;

    // control state
    lzf_pkg::state_t                 state_reg, state_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic                            moved_reg, moved_next;
    logic                            live_mode_reg, live_mode_next;
    logic [lzf_pkg::IDLE_W-1:0]      idle_reg, idle_next;
    logic [ChW-1:0]                  fade_step_reg;
    logic [lzf_pkg::IDLE_W-1:0]      timeout_reg;

    // per-zone valid bits standing in for the reset clear
    logic [ZONE_COUNT-1:0]           tgt_vld_reg, shw_vld_reg, liv_vld_reg;
    logic                            tgt_rv_reg, shw_rv_reg, liv_rv_reg;

    // result registers
    logic                            out_valid_reg, out_valid_next;
    logic [ZoneW-1:0]                out_zone_reg;
    lzf_pkg::color_t                 out_color_reg;
    logic                            frame_last_reg;

    // decoded command
    logic                            accept;
    logic                            zone_ok;
    logic [AW-1:0]                   wr_zone;
    lzf_pkg::color_t                 in_color;
    logic [lzf_pkg::IDLE_W-1:0]      idle_inc;
    logic                            expire;

    // sweep control
    logic                            issue;
    logic                            proc;
    logic                            last_proc;
    logic [AW-1:0]                   rd_zone;
    logic [AW-1:0]                   proc_zone;

    // memory ports
    lzf_pkg::color_t                 tgt_rdata, shw_rdata, liv_rdata;
    lzf_pkg::color_t                 tgt_col, shw_col, liv_col;
    logic                            tgt_we, liv_we, shw_we;
    lzf_pkg::color_t                 shw_wdata;

    // fade unit
    lzf_pkg::color_t                 fade_col;
    logic                            fade_moved;
    logic [ChW-1:0]                  step_eff;
    logic                            moved_any;

    // command decode
    assign accept   = start && (state_reg == lzf_pkg::ST_IDLE);
    assign zone_ok  = ({1'b0, zone} < (ZoneW + 1)'(ZONE_COUNT));
    assign wr_zone  = zone[AW-1:0];
    assign in_color = '{red: red, green: green, blue: blue};
    assign idle_inc = (idle_reg == lzf_pkg::IDLE_MAX) ? idle_reg : idle_reg + 16'd1;
    assign expire   = (idle_inc >= timeout_reg);

    // sweep position
    assign issue     = (state_reg != lzf_pkg::ST_IDLE) && (cnt_reg < CW'(ZONE_COUNT));
    assign proc      = (state_reg != lzf_pkg::ST_IDLE) && (cnt_reg != '0);
    assign last_proc = (cnt_reg == CW'(ZONE_COUNT));
    assign rd_zone   = cnt_reg[AW-1:0];
    assign proc_zone = AW'(cnt_reg - CW'(1));

    // never-written entries read as zero
    assign tgt_col = tgt_rv_reg ? tgt_rdata : '0;
    assign shw_col = shw_rv_reg ? shw_rdata : '0;
    assign liv_col = liv_rv_reg ? liv_rdata : '0;

    assign step_eff  = (fade_step_reg == '0) ? ChW'(1) : fade_step_reg;
    assign moved_any = moved_reg || (proc && fade_moved);

    // memory writes
    assign tgt_we = accept && (req_type == lzf_pkg::REQ_HOME) && zone_ok;
    assign liv_we = accept && (req_type == lzf_pkg::REQ_LIVE) && zone_ok;
    assign shw_we = proc && ((state_reg == lzf_pkg::ST_COPY) ||
                             (state_reg == lzf_pkg::ST_FADE));
    assign shw_wdata = (state_reg == lzf_pkg::ST_COPY) ? liv_col : fade_col;

    lzf_ram #(
        .WIDTH (lzf_pkg::COLOR_W),
        .DEPTH (ZONE_COUNT)
    ) u_target_ram (
        .clk   (clk),
        .we    (tgt_we),
        .waddr (wr_zone),
        .wdata (in_color),
        .raddr (rd_zone),
        .rdata (tgt_rdata)
    );

    lzf_ram #(
        .WIDTH (lzf_pkg::COLOR_W),
        .DEPTH (ZONE_COUNT)
    ) u_live_ram (
        .clk   (clk),
        .we    (liv_we),
        .waddr (wr_zone),
        .wdata (in_color),
        .raddr (rd_zone),
        .rdata (liv_rdata)
    );

    lzf_ram #(
        .WIDTH (lzf_pkg::COLOR_W),
        .DEPTH (ZONE_COUNT)
    ) u_shown_ram (
        .clk   (clk),
        .we    (shw_we),
        .waddr (proc_zone),
        .wdata (shw_wdata),
        .raddr (rd_zone),
        .rdata (shw_rdata)
    );

    lzf_fade u_fade (
        .cur   (shw_col),
        .goal  (tgt_col),
        .step  (step_eff),
        .nxt   (fade_col),
        .moved (fade_moved)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lzf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if ((req_type == lzf_pkg::REQ_LIVE) && frame_end)
                    begin
                        state_next = lzf_pkg::ST_EMIT_LIVE;
                    end
                    else if (req_type == lzf_pkg::REQ_TICK)
                    begin
                        if (!live_mode_reg)
                        begin
                            state_next = lzf_pkg::ST_FADE;
                        end
                        else if (expire)
                        begin
                            state_next = lzf_pkg::ST_COPY;
                        end
                    end
                end
            end
            lzf_pkg::ST_FADE:
            begin
                if (last_proc)
                begin
                    state_next = moved_any ? lzf_pkg::ST_EMIT_SHOWN : lzf_pkg::ST_IDLE;
                end
            end
            lzf_pkg::ST_EMIT_LIVE, lzf_pkg::ST_COPY, lzf_pkg::ST_EMIT_SHOWN:
            begin
                if (last_proc)
                begin
                    state_next = lzf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lzf_pkg::ST_IDLE;
            end
        endcase
    end

    // counters, mode and result strobe
    always_comb
    begin
        cnt_next       = cnt_reg;
        moved_next     = moved_reg;
        live_mode_next = live_mode_reg;
        idle_next      = idle_reg;
        out_valid_next = 1'b0;
        case (state_reg)
            lzf_pkg::ST_IDLE:
            begin
                cnt_next   = '0;
                moved_next = 1'b0;
                if (accept && (req_type == lzf_pkg::REQ_LIVE) && frame_end)
                begin
                    live_mode_next = 1'b1;
                    idle_next      = '0;
                end
                else if (accept && (req_type == lzf_pkg::REQ_TICK) && live_mode_reg)
                begin
                    idle_next = idle_inc;
                    if (expire)
                    begin
                        live_mode_next = 1'b0;
                    end
                end
            end
            lzf_pkg::ST_FADE:
            begin
                moved_next = moved_any;
                cnt_next   = last_proc ? '0 : cnt_reg + CW'(1);
            end
            lzf_pkg::ST_EMIT_LIVE, lzf_pkg::ST_EMIT_SHOWN:
            begin
                out_valid_next = proc;
                cnt_next       = last_proc ? '0 : cnt_reg + CW'(1);
            end
            lzf_pkg::ST_COPY:
            begin
                cnt_next = last_proc ? '0 : cnt_reg + CW'(1);
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lzf_pkg::ST_IDLE;
            cnt_reg       <= '0;
            moved_reg     <= 1'b0;
            live_mode_reg <= 1'b0;
            idle_reg      <= '0;
            out_valid_reg <= 1'b0;
            fade_step_reg <= lzf_pkg::FADE_STEP_RST;
            timeout_reg   <= lzf_pkg::TIMEOUT_RST;
            tgt_vld_reg   <= '0;
            shw_vld_reg   <= '0;
            liv_vld_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            moved_reg     <= moved_next;
            live_mode_reg <= live_mode_next;
            idle_reg      <= idle_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == lzf_pkg::CFG_FADE_STEP))
            begin
                fade_step_reg <= cfg_data[ChW-1:0];
            end
            if (cfg_we && (cfg_index == lzf_pkg::CFG_TIMEOUT))
            begin
                timeout_reg <= cfg_data[lzf_pkg::IDLE_W-1:0];
            end
            if (tgt_we)
            begin
                tgt_vld_reg[wr_zone] <= 1'b1;
            end
            if (liv_we)
            begin
                liv_vld_reg[wr_zone] <= 1'b1;
            end
            if (shw_we)
            begin
                shw_vld_reg[proc_zone] <= 1'b1;
            end
        end
    end

    // valid bits travel with the read, plus the result payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            tgt_rv_reg <= tgt_vld_reg[rd_zone];
            shw_rv_reg <= shw_vld_reg[rd_zone];
            liv_rv_reg <= liv_vld_reg[rd_zone];
        end
        if (out_valid_next)
        begin
            out_zone_reg   <= ZoneW'(proc_zone);
            out_color_reg  <= (state_reg == lzf_pkg::ST_EMIT_LIVE) ? liv_col : shw_col;
            frame_last_reg <= last_proc;
        end
    end

    // outputs
    assign busy       = (state_reg != lzf_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_zone   = out_zone_reg;
    assign out_red    = out_color_reg.red;
    assign out_green  = out_color_reg.green;
    assign out_blue   = out_color_reg.blue;
    assign frame_last = frame_last_reg;

endmodule

`default_nettype wire
